@@ hdl/fce_pkg.sv @@
// Package for the FAT chain engine: table size, field widths, codes,
// controller states and the command and status structs between controller and datapath.
// No dependencies.
package fce_pkg;

  // Table geometry.
  localparam int ENTRIES = 4096;
  localparam int CL_W    = $clog2(ENTRIES);

  // Field widths.
  localparam int MODE_W    = 2;
  localparam int CLUSTER_W = 12;
  localparam int IDX_W     = 13;
  localparam int LINK_W    = 16;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  typedef logic [CL_W-1:0]      addr_t;
  typedef logic [LINK_W-1:0]    link_t;
  typedef logic [LINK_W:0]      link_ext_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CLUSTER_W-1:0] cluster_t;

  // Range limits for link and address checks.
  localparam link_ext_t ENTRIES_V = link_ext_t'(ENTRIES);
  localparam addr_t     LAST_ADDR = addr_t'(ENTRIES - 1);

  // Register reset values; the clearing pass writes the free marker's reset value.
  localparam link_t FREE_RESET = '0;
  localparam link_t END_RESET  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREE_MARKER,
    REG_END_MARKER
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD,
    MODE_MAP,
    MODE_TRUNC,
    MODE_ALLOC
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_BEYOND,
    ST_NOFREE
  } status_t;

  // Read address sources.
  typedef enum logic [1:0] {
    RA_HEAD,
    RA_LINK,
    RA_ZERO,
    RA_SCAN_NEXT
  } ra_sel_t;

  // Write address sources.
  typedef enum logic [1:0] {
    WA_HEAD,
    WA_P,
    WA_N,
    WA_SCAN
  } wa_sel_t;

  // Write data sources.
  typedef enum logic [2:0] {
    WD_VALUE,
    WD_END,
    WD_FREE,
    WD_SCAN,
    WD_CLEAR
  } wd_sel_t;

  // Result cluster sources.
  typedef enum logic [2:0] {
    CL_ZERO,
    CL_HEAD,
    CL_LINK,
    CL_N,
    CL_SCAN
  } cl_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_MAP_WALK,
    S_SCAN,
    S_APP_WR1,
    S_APP_WR2,
    S_ALLOC_WR,
    S_TR_HEAD,
    S_TR_WALK,
    S_TR_WR1,
    S_TR_WR2,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    ra_sel_t ra_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    p_from_head;
    logic    p_from_link;
    logic    p_from_n;
    logic    n_from_link;
    logic    i_clr;
    logic    i_inc;
    logic    steps_clr;
    logic    steps_inc;
    logic    sa_clr;
    logic    sa_inc;
    logic    res_set;
    status_t res_status;
    cl_sel_t res_cl_sel;
    logic    res_appended;
    logic    res_freed;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  head_oor;
    logic  idx_zero;
    logic  idx_hit;
    logic  rd_is_end;
    logic  rd_is_free;
    logic  rd_oor;
    logic  steps_last;
    logic  scan_last;
    logic  out_free;
  } dp_status_t;

endpackage

@@ hdl/fce_if.sv @@
// Handshake interfaces of the FAT chain engine: request, response and configuration write.
// Depends on fce_pkg for the field widths.
interface fce_req_if;
  logic                         valid;
  logic                         ready;
  logic [fce_pkg::MODE_W-1:0]    mode;
  logic [fce_pkg::CLUSTER_W-1:0] head_cluster;
  logic [fce_pkg::IDX_W-1:0]     chain_index;
  logic [fce_pkg::LINK_W-1:0]    entry_value;

  modport source(output valid, output mode, output head_cluster, output chain_index,
                 output entry_value, input ready);
  modport sink(input valid, input mode, input head_cluster, input chain_index,
               input entry_value, output ready);
endinterface

interface fce_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [fce_pkg::STATUS_W-1:0]  status;
  logic [fce_pkg::CLUSTER_W-1:0] cluster;
  logic                         appended;
  logic                         freed;

  modport source(output valid, output status, output cluster, output appended,
                 output freed, input ready);
  modport sink(input valid, input status, input cluster, input appended,
               input freed, output ready);
endinterface

interface fce_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fce_pkg::CFG_IDX_W-1:0] index;
  logic [fce_pkg::LINK_W-1:0]    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ hdl/fce_datapath.sv @@
// Datapath of the FAT chain engine: link table memory, marker registers, walk and
// scan registers, result staging and the output register. Depends on fce_pkg.
module fce_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  fce_pkg::ctrl_cmd_t           cmd,
  output fce_pkg::dp_status_t          dps,
  input  logic [fce_pkg::MODE_W-1:0]    req_mode,
  input  logic [fce_pkg::CLUSTER_W-1:0] req_head_cluster,
  input  logic [fce_pkg::IDX_W-1:0]     req_chain_index,
  input  logic [fce_pkg::LINK_W-1:0]    req_entry_value,
  input  logic                         cfg_wr,
  input  logic [fce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fce_pkg::LINK_W-1:0]    cfg_data,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output logic [fce_pkg::STATUS_W-1:0]  rsp_status,
  output logic [fce_pkg::CLUSTER_W-1:0] rsp_cluster,
  output logic                         rsp_appended,
  output logic                         rsp_freed
);

  logic [fce_pkg::LINK_W-1:0] mem [fce_pkg::ENTRIES];

  fce_pkg::link_t    free_marker;
  fce_pkg::link_t    end_marker;
  fce_pkg::link_t    rd_data;
  fce_pkg::mode_t    mode_q;
  fce_pkg::cluster_t head_q;
  fce_pkg::idx_t     idx_q;
  fce_pkg::link_t    value_q;
  fce_pkg::addr_t    p;
  fce_pkg::addr_t    n;
  fce_pkg::idx_t     i;
  fce_pkg::addr_t    steps;
  fce_pkg::addr_t    sa;
  fce_pkg::status_t  res_status;
  fce_pkg::cluster_t res_cluster;
  logic              res_appended;
  logic              res_freed;
  fce_pkg::addr_t    rd_addr;
  fce_pkg::addr_t    wr_addr;
  fce_pkg::link_t    wr_data;
  fce_pkg::cluster_t cl_value;

  // Marker registers, written from the configuration port.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_marker <= fce_pkg::FREE_RESET;
      end_marker  <= fce_pkg::END_RESET;
    end else if (cfg_wr) begin
      unique case (fce_pkg::cfg_reg_t'(cfg_index))
        fce_pkg::REG_FREE_MARKER: free_marker <= cfg_data;
        fce_pkg::REG_END_MARKER:  end_marker  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address and data selection for the table ports.
  always_comb begin
    case (cmd.ra_sel)
      fce_pkg::RA_HEAD:      rd_addr = fce_pkg::addr_t'(head_q);
      fce_pkg::RA_LINK:      rd_addr = fce_pkg::addr_t'(rd_data);
      fce_pkg::RA_ZERO:      rd_addr = '0;
      default:               rd_addr = sa + fce_pkg::addr_t'(1);
    endcase
    case (cmd.wa_sel)
      fce_pkg::WA_HEAD: wr_addr = fce_pkg::addr_t'(head_q);
      fce_pkg::WA_P:    wr_addr = p;
      fce_pkg::WA_N:    wr_addr = n;
      default:          wr_addr = sa;
    endcase
    case (cmd.wd_sel)
      fce_pkg::WD_VALUE: wr_data = value_q;
      fce_pkg::WD_END:   wr_data = end_marker;
      fce_pkg::WD_FREE:  wr_data = free_marker;
      fce_pkg::WD_SCAN:  wr_data = fce_pkg::link_t'(sa);
      default:           wr_data = fce_pkg::FREE_RESET;
    endcase
  end

  // Link table: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Captured item fields.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q  <= fce_pkg::mode_t'(req_mode);
      head_q  <= req_head_cluster;
      idx_q   <= req_chain_index;
      value_q <= req_entry_value;
    end
  end

  // Walk registers: previous and current cluster, position and link count.
  always_ff @(posedge clk) begin
    if (cmd.p_from_head) begin
      p <= fce_pkg::addr_t'(head_q);
    end else if (cmd.p_from_link) begin
      p <= fce_pkg::addr_t'(rd_data);
    end else if (cmd.p_from_n) begin
      p <= n;
    end
    if (cmd.n_from_link) begin
      n <= fce_pkg::addr_t'(rd_data);
    end
    if (cmd.i_clr) begin
      i <= '0;
    end else if (cmd.i_inc) begin
      i <= i + fce_pkg::idx_t'(1);
    end
    if (cmd.steps_clr) begin
      steps <= '0;
    end else if (cmd.steps_inc) begin
      steps <= steps + fce_pkg::addr_t'(1);
    end
  end

  // Scan address, also the sweep address of the clearing pass after reset.
  always_ff @(posedge clk) begin
    if (rst || cmd.sa_clr) begin
      sa <= '0;
    end else if (cmd.sa_inc) begin
      sa <= sa + fce_pkg::addr_t'(1);
    end
  end

  // Result staging.
  always_comb begin
    case (cmd.res_cl_sel)
      fce_pkg::CL_HEAD: cl_value = head_q;
      fce_pkg::CL_LINK: cl_value = fce_pkg::cluster_t'(rd_data);
      fce_pkg::CL_N:    cl_value = fce_pkg::cluster_t'(n);
      fce_pkg::CL_SCAN: cl_value = fce_pkg::cluster_t'(sa);
      default:          cl_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status   <= cmd.res_status;
      res_cluster  <= cl_value;
      res_appended <= cmd.res_appended;
      res_freed    <= cmd.res_freed;
    end
  end

  // Output register; it holds a finished item while the engine takes the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_status   <= res_status;
      rsp_cluster  <= res_cluster;
      rsp_appended <= res_appended;
      rsp_freed    <= res_freed;
    end
  end

  // Status flags for the controller.
  always_comb begin
    dps.mode       = mode_q;
    dps.head_oor   = fce_pkg::link_ext_t'(head_q) >= fce_pkg::ENTRIES_V;
    dps.idx_zero   = (idx_q == '0);
    dps.idx_hit    = ((i + fce_pkg::idx_t'(1)) == idx_q);
    dps.rd_is_end  = (rd_data == end_marker);
    dps.rd_is_free = (rd_data == free_marker);
    dps.rd_oor     = fce_pkg::link_ext_t'(rd_data) >= fce_pkg::ENTRIES_V;
    dps.steps_last = (steps == fce_pkg::LAST_ADDR);
    dps.scan_last  = (sa == fce_pkg::LAST_ADDR);
    dps.out_free   = !rsp_valid || rsp_ready;
  end

  // A new result is only moved out when the output register is free.
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("output register overwritten while still full");

  // At most one source loads the previous-cluster register.
  a_p_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.p_from_head, cmd.p_from_link, cmd.p_from_n}))
    else $error("conflicting loads of the previous-cluster register");

  // An append write never links to a scan address outside the table.
  a_wr_p_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en && cmd.wd_sel == fce_pkg::WD_SCAN) |-> (sa <= fce_pkg::LAST_ADDR))
    else $error("append writes a cluster outside the table");

endmodule

@@ hdl/fce_controller.sv @@
// Controller of the FAT chain engine: the sequencer for load, map, truncate and
// allocate, and the clearing pass after reset. Depends on fce_pkg.
module fce_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  fce_pkg::dp_status_t dps,
  output fce_pkg::ctrl_cmd_t  cmd
);

  fce_pkg::state_t state;
  fce_pkg::state_t state_next;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fce_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      // Write the free marker's reset value into every entry.
      fce_pkg::S_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = fce_pkg::WA_SCAN;
        cmd.wd_sel = fce_pkg::WD_CLEAR;
        if (dps.scan_last) begin
          cmd.sa_clr = 1'b1;
          state_next = fce_pkg::S_IDLE;
        end else begin
          cmd.sa_inc = 1'b1;
        end
      end

      fce_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = fce_pkg::S_DISPATCH;
        end
      end

      fce_pkg::S_DISPATCH: begin
        unique case (dps.mode)
          fce_pkg::MODE_LOAD: begin
            cmd.res_set    = 1'b1;
            cmd.res_cl_sel = fce_pkg::CL_HEAD;
            if (dps.head_oor) begin
              cmd.res_status = fce_pkg::ST_BEYOND;
            end else begin
              cmd.wr_en      = 1'b1;
              cmd.wa_sel     = fce_pkg::WA_HEAD;
              cmd.wd_sel     = fce_pkg::WD_VALUE;
              cmd.res_status = fce_pkg::ST_OK;
            end
            state_next = fce_pkg::S_EMIT;
          end
          fce_pkg::MODE_MAP: begin
            if (dps.head_oor) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = fce_pkg::ST_BEYOND;
              cmd.res_cl_sel = fce_pkg::CL_ZERO;
              state_next     = fce_pkg::S_EMIT;
            end else if (dps.idx_zero) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = fce_pkg::ST_OK;
              cmd.res_cl_sel = fce_pkg::CL_HEAD;
              state_next     = fce_pkg::S_EMIT;
            end else begin
              cmd.rd_en       = 1'b1;
              cmd.ra_sel      = fce_pkg::RA_HEAD;
              cmd.p_from_head = 1'b1;
              cmd.i_clr       = 1'b1;
              state_next      = fce_pkg::S_MAP_WALK;
            end
          end
          fce_pkg::MODE_TRUNC: begin
            if (dps.head_oor) begin
              cmd.res_set    = 1'b1;
              cmd.res_status = fce_pkg::ST_BEYOND;
              cmd.res_cl_sel = fce_pkg::CL_ZERO;
              state_next     = fce_pkg::S_EMIT;
            end else begin
              cmd.rd_en       = 1'b1;
              cmd.ra_sel      = fce_pkg::RA_HEAD;
              cmd.p_from_head = 1'b1;
              state_next      = fce_pkg::S_TR_HEAD;
            end
          end
          fce_pkg::MODE_ALLOC: begin
            cmd.rd_en  = 1'b1;
            cmd.ra_sel = fce_pkg::RA_ZERO;
            cmd.sa_clr = 1'b1;
            state_next = fce_pkg::S_SCAN;
          end
          default: state_next = fce_pkg::S_IDLE;
        endcase
      end

      // The read data holds the entry of the cluster at the current position.
      fce_pkg::S_MAP_WALK: begin
        if (dps.rd_is_end) begin
          if (!dps.idx_hit) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = fce_pkg::ST_BEYOND;
            cmd.res_cl_sel = fce_pkg::CL_ZERO;
            state_next     = fce_pkg::S_EMIT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.ra_sel = fce_pkg::RA_ZERO;
            cmd.sa_clr = 1'b1;
            state_next = fce_pkg::S_SCAN;
          end
        end else begin
          cmd.p_from_link = 1'b1;
          if (dps.rd_oor) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = fce_pkg::ST_BEYOND;
            cmd.res_cl_sel = fce_pkg::CL_ZERO;
            state_next     = fce_pkg::S_EMIT;
          end else if (dps.idx_hit) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = fce_pkg::ST_OK;
            cmd.res_cl_sel = fce_pkg::CL_LINK;
            state_next     = fce_pkg::S_EMIT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.ra_sel = fce_pkg::RA_LINK;
            cmd.i_inc  = 1'b1;
          end
        end
      end

      // Lowest free entry search; the read data holds the entry at the scan address.
      fce_pkg::S_SCAN: begin
        if (dps.rd_is_free) begin
          if (dps.mode == fce_pkg::MODE_MAP) begin
            state_next = fce_pkg::S_APP_WR1;
          end else begin
            state_next = fce_pkg::S_ALLOC_WR;
          end
        end else if (dps.scan_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = fce_pkg::ST_NOFREE;
          cmd.res_cl_sel = fce_pkg::CL_ZERO;
          state_next     = fce_pkg::S_EMIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.ra_sel = fce_pkg::RA_SCAN_NEXT;
          cmd.sa_inc = 1'b1;
        end
      end

      // Link the old last cluster to the new one, then mark the new one as the end.
      fce_pkg::S_APP_WR1: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = fce_pkg::WA_P;
        cmd.wd_sel = fce_pkg::WD_SCAN;
        state_next = fce_pkg::S_APP_WR2;
      end

      fce_pkg::S_APP_WR2: begin
        cmd.wr_en        = 1'b1;
        cmd.wa_sel       = fce_pkg::WA_SCAN;
        cmd.wd_sel       = fce_pkg::WD_END;
        cmd.res_set      = 1'b1;
        cmd.res_status   = fce_pkg::ST_OK;
        cmd.res_cl_sel   = fce_pkg::CL_SCAN;
        cmd.res_appended = 1'b1;
        state_next       = fce_pkg::S_EMIT;
      end

      fce_pkg::S_ALLOC_WR: begin
        cmd.wr_en      = 1'b1;
        cmd.wa_sel     = fce_pkg::WA_SCAN;
        cmd.wd_sel     = fce_pkg::WD_END;
        cmd.res_set    = 1'b1;
        cmd.res_status = fce_pkg::ST_OK;
        cmd.res_cl_sel = fce_pkg::CL_SCAN;
        state_next     = fce_pkg::S_EMIT;
      end

      // The read data holds the head entry.
      fce_pkg::S_TR_HEAD: begin
        if (dps.rd_is_end) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = fce_pkg::ST_OK;
          cmd.res_cl_sel = fce_pkg::CL_HEAD;
          state_next     = fce_pkg::S_EMIT;
        end else begin
          cmd.n_from_link = 1'b1;
          cmd.steps_clr   = 1'b1;
          if (dps.rd_oor) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = fce_pkg::ST_BEYOND;
            cmd.res_cl_sel = fce_pkg::CL_ZERO;
            state_next     = fce_pkg::S_EMIT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.ra_sel = fce_pkg::RA_LINK;
            state_next = fce_pkg::S_TR_WALK;
          end
        end
      end

      // The read data holds the entry of the cluster after the previous one.
      fce_pkg::S_TR_WALK: begin
        if (dps.rd_is_end) begin
          state_next = fce_pkg::S_TR_WR1;
        end else begin
          cmd.p_from_n    = 1'b1;
          cmd.n_from_link = 1'b1;
          cmd.steps_inc   = 1'b1;
          if (dps.rd_oor || dps.steps_last) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = fce_pkg::ST_BEYOND;
            cmd.res_cl_sel = fce_pkg::CL_ZERO;
            state_next     = fce_pkg::S_EMIT;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.ra_sel = fce_pkg::RA_LINK;
          end
        end
      end

      // Make the previous cluster the end, then release the last one.
      fce_pkg::S_TR_WR1: begin
        cmd.wr_en  = 1'b1;
        cmd.wa_sel = fce_pkg::WA_P;
        cmd.wd_sel = fce_pkg::WD_END;
        state_next = fce_pkg::S_TR_WR2;
      end

      fce_pkg::S_TR_WR2: begin
        cmd.wr_en      = 1'b1;
        cmd.wa_sel     = fce_pkg::WA_N;
        cmd.wd_sel     = fce_pkg::WD_FREE;
        cmd.res_set    = 1'b1;
        cmd.res_status = fce_pkg::ST_OK;
        cmd.res_cl_sel = fce_pkg::CL_N;
        cmd.res_freed  = 1'b1;
        state_next     = fce_pkg::S_EMIT;
      end

      // Hand the staged result to the output register once it is free.
      fce_pkg::S_EMIT: begin
        if (dps.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = fce_pkg::S_IDLE;
        end
      end

      default: state_next = fce_pkg::S_IDLE;
    endcase
  end

  // An item is only captured from the idle state.
  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (state == fce_pkg::S_IDLE && req_valid))
    else $error("item captured outside the idle state");

  // Releasing the last cluster always follows the unlink write.
  a_trunc_pair: assert property (@(posedge clk) disable iff (rst)
    (state == fce_pkg::S_TR_WR1) |=> (state == fce_pkg::S_TR_WR2))
    else $error("truncate unlink not followed by release");

  // Every result staged by the sequencer is moved out before the next item is taken.
  a_stage_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.res_set |=> (state == fce_pkg::S_EMIT))
    else $error("staged result not followed by emit");

endmodule

@@ hdl/fat_chain_engine.sv @@
// Top level of the FAT chain engine: request, response and configuration channels.
// Depends on fce_pkg, fce_if, fce_controller and fce_datapath.
//
// The engine keeps a 4096-entry FAT link table in one memory with a single read
// port, and every request is worked one table read per cycle by a sequencer; it
// stalls while a staged result waits for the output register to free. After reset a
// clearing pass writes the free marker's reset value into every entry; no request
// is taken during it, while configuration writes are taken at any time. The walk
// along links and the free scan both run at the read port's rate, so chain length
// and the position of the lowest free entry set how long an item takes. A finished
// result waits in an output register while the next request is taken.
module fat_chain_engine (
  input  logic  clk,
  input  logic  rst,
  fce_req_if.sink   req,
  fce_rsp_if.source rsp,
  fce_cfg_if.sink   cfg
);

  fce_pkg::ctrl_cmd_t  cmd;
  fce_pkg::dp_status_t dps;

  // The marker registers take a write in any cycle.
  assign cfg.ready = 1'b1;

  fce_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .dps       (dps),
    .cmd       (cmd)
  );

  fce_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .dps               (dps),
    .req_mode          (req.mode),
    .req_head_cluster  (req.head_cluster),
    .req_chain_index   (req.chain_index),
    .req_entry_value   (req.entry_value),
    .cfg_wr            (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_cluster       (rsp.cluster),
    .rsp_appended      (rsp.appended),
    .rsp_freed         (rsp.freed)
  );

endmodule

@@ sim/fat_chain_engine_tb.sv @@
// Self-checking testbench for the FAT chain engine: load, map, truncate and allocate requests
// against a local link table that predicts every response. Depends on fce_pkg, fce_if and the
// fat_chain_engine top level.
`timescale 1ns / 100ps

module fat_chain_engine_tb;

  localparam int LIMIT_NS    = 500_000_000;
  localparam int DRAIN_LIMIT = 40000;
  localparam int MAX_HEADS   = 24;

  typedef struct {
    fce_pkg::mode_t    mode;
    fce_pkg::cluster_t head;
    fce_pkg::idx_t     idx;
    fce_pkg::link_t    value;
  } fat_request_t;

  typedef struct packed {
    fce_pkg::status_t  status;
    fce_pkg::cluster_t cluster;
    logic              appended;
    logic              freed;
  } fat_result_t;

  typedef struct {
    fat_request_t rq;
    bit           typed;
    fat_result_t  res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  fce_req_if req ();
  fce_rsp_if rsp ();
  fce_cfg_if cfg ();

  fat_chain_engine DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  // Predicted link table and marker registers.
  fce_pkg::link_t link_mem [fce_pkg::ENTRIES];
  fce_pkg::link_t free_mk;
  fce_pkg::link_t end_mk;

  fat_result_t  pending_results [$];
  int unsigned  chain_heads [$];
  dir_row_t     dir_rows [$];
  int           mismatches = 0;
  int           burst_left = 0;
  int           stall_left = 0;
  int           stall_mode = 0;
  int unsigned  stall_tick = 0;

  always #5 clk = ~clk;

  function automatic fat_result_t mk_result(fce_pkg::status_t st, int unsigned cl, bit app,
                                            bit fr);
    fat_result_t r;
    r.status   = st;
    r.cluster  = fce_pkg::cluster_t'(cl);
    r.appended = app;
    r.freed    = fr;
    return r;
  endfunction

  // Lowest entry that holds the free marker.
  function automatic bit lowest_free(output int unsigned slot);
    for (int i = 0; i < fce_pkg::ENTRIES; i++) begin
      if (link_mem[i] == free_mk) begin
        slot = unsigned'(i);
        return 1'b1;
      end
    end
    slot = 0;
    return 1'b0;
  endfunction

  // Walk to a chain position, growing the chain by one when the position is one past its end.
  function automatic fat_result_t walk_map(int unsigned head, int unsigned idx);
    int unsigned p;
    int unsigned v;
    int unsigned nc;
    p = head;
    if (p >= fce_pkg::ENTRIES) return mk_result(fce_pkg::ST_BEYOND, 0, 1'b0, 1'b0);
    for (int unsigned i = 0; i < idx; i++) begin
      v = 32'(link_mem[p]);
      if (v == 32'(end_mk)) begin
        if (i + 1 != idx) return mk_result(fce_pkg::ST_BEYOND, 0, 1'b0, 1'b0);
        if (!lowest_free(nc)) return mk_result(fce_pkg::ST_NOFREE, 0, 1'b0, 1'b0);
        link_mem[p]  = fce_pkg::link_t'(nc);
        link_mem[nc] = end_mk;
        return mk_result(fce_pkg::ST_OK, nc, 1'b1, 1'b0);
      end
      p = v;
      if (p >= fce_pkg::ENTRIES) return mk_result(fce_pkg::ST_BEYOND, 0, 1'b0, 1'b0);
    end
    return mk_result(fce_pkg::ST_OK, p, 1'b0, 1'b0);
  endfunction

  // Release the last cluster of a chain, keeping at least one.
  function automatic fat_result_t cut_tail(int unsigned head);
    int unsigned p;
    int unsigned n;
    int unsigned steps;
    p = head;
    steps = 0;
    if (p >= fce_pkg::ENTRIES) return mk_result(fce_pkg::ST_BEYOND, 0, 1'b0, 1'b0);
    if (link_mem[p] == end_mk) return mk_result(fce_pkg::ST_OK, p, 1'b0, 1'b0);
    n = 32'(link_mem[p]);
    forever begin
      if (n >= fce_pkg::ENTRIES || steps >= fce_pkg::ENTRIES)
        return mk_result(fce_pkg::ST_BEYOND, 0, 1'b0, 1'b0);
      if (link_mem[n] == end_mk) break;
      p = n;
      n = 32'(link_mem[p]);
      steps++;
    end
    link_mem[p] = end_mk;
    link_mem[n] = free_mk;
    return mk_result(fce_pkg::ST_OK, n, 1'b0, 1'b1);
  endfunction

  function automatic fat_result_t predict_request(fat_request_t rq);
    int unsigned nc;
    case (rq.mode)
      fce_pkg::MODE_LOAD: begin
        if (rq.head < fce_pkg::ENTRIES) begin
          link_mem[rq.head] = rq.value;
          return mk_result(fce_pkg::ST_OK, 32'(rq.head), 1'b0, 1'b0);
        end
        return mk_result(fce_pkg::ST_BEYOND, 32'(rq.head), 1'b0, 1'b0);
      end
      fce_pkg::MODE_MAP:   return walk_map(32'(rq.head), 32'(rq.idx));
      fce_pkg::MODE_TRUNC: return cut_tail(32'(rq.head));
      default: begin
        if (!lowest_free(nc)) return mk_result(fce_pkg::ST_NOFREE, 0, 1'b0, 1'b0);
        link_mem[nc] = end_mk;
        return mk_result(fce_pkg::ST_OK, nc, 1'b0, 1'b0);
      end
    endcase
  endfunction

  function automatic void add_row(fce_pkg::mode_t m, int unsigned head, int unsigned idx,
                                  int unsigned value, bit typed, fce_pkg::status_t st,
                                  int unsigned cl, bit app, bit fr);
    dir_row_t row;
    row.rq.mode  = m;
    row.rq.head  = fce_pkg::cluster_t'(head);
    row.rq.idx   = fce_pkg::idx_t'(idx);
    row.rq.value = fce_pkg::link_t'(value);
    row.typed    = typed;
    row.res      = mk_result(st, cl, app, fr);
    dir_rows.push_back(row);
  endfunction

  function automatic int unsigned pick_head();
    if (chain_heads.size() > 0 && $urandom_range(0, 9) < 8)
      return chain_heads[$urandom_range(0, chain_heads.size() - 1)];
    return $urandom_range(0, fce_pkg::ENTRIES - 1);
  endfunction

  function automatic void note_head(int unsigned cl);
    if (chain_heads.size() >= MAX_HEADS)
      chain_heads.delete($urandom_range(0, chain_heads.size() - 1));
    chain_heads.push_back(cl);
  endfunction

  // Send one request item in bursts with random gaps; predict it once it is accepted.
  task automatic issue(input fat_request_t rq, input bit typed, input fat_result_t typed_res,
                       output fat_result_t predicted);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid        <= 1'b1;
    req.mode         <= rq.mode;
    req.head_cluster <= rq.head;
    req.chain_index  <= rq.idx;
    req.entry_value  <= rq.value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predicted = predict_request(rq);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // Wait for every outstanding response, with a bound; leftovers count as failures.
  task automatic drain(input int settle);
    int waited;
    waited = 0;
    req.valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0d responses never arrived", pending_results.size());
      mismatches += pending_results.size();
      pending_results.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input fce_pkg::cfg_reg_t index, input fce_pkg::link_t data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (index == fce_pkg::REG_FREE_MARKER) free_mk = data;
    else end_mk = data;
    @(posedge clk);
  endtask

  // Change both markers once the engine has gone quiet.
  task automatic retune_markers(input fce_pkg::link_t free_val, input fce_pkg::link_t end_val);
    drain(4);
    write_reg(fce_pkg::REG_FREE_MARKER, free_val);
    write_reg(fce_pkg::REG_END_MARKER, end_val);
  endtask

  task automatic run_random(input int count);
    fat_request_t rq;
    fat_result_t  got;
    fat_result_t  none;
    int           pick;
    int           vpick;
    none = mk_result(fce_pkg::ST_OK, 0, 1'b0, 1'b0);
    for (int n = 0; n < count; n++) begin
      pick     = $urandom_range(0, 99);
      rq.head  = fce_pkg::cluster_t'(pick_head());
      rq.idx   = '0;
      rq.value = fce_pkg::link_t'($urandom_range(0, 65535));
      if (pick < 35) begin
        rq.mode = fce_pkg::MODE_MAP;
        vpick = $urandom_range(0, 99);
        if (vpick < 85) rq.idx = fce_pkg::idx_t'($urandom_range(0, 5));
        else if (vpick < 97) rq.idx = fce_pkg::idx_t'($urandom_range(0, fce_pkg::ENTRIES));
        else rq.idx = fce_pkg::idx_t'(fce_pkg::ENTRIES);
      end else if (pick < 55) begin
        rq.mode = fce_pkg::MODE_TRUNC;
      end else if (pick < 73) begin
        rq.mode = fce_pkg::MODE_ALLOC;
      end else begin
        rq.mode = fce_pkg::MODE_LOAD;
        if ($urandom_range(0, 1) == 0)
          rq.head = fce_pkg::cluster_t'($urandom_range(0, fce_pkg::ENTRIES - 1));
        vpick = $urandom_range(0, 99);
        if (vpick < 25) rq.value = end_mk;
        else if (vpick < 45) rq.value = free_mk;
        else if (vpick < 70) rq.value = fce_pkg::link_t'(pick_head());
      end
      issue(rq, 1'b0, none, got);
      if (rq.mode == fce_pkg::MODE_ALLOC && got.status == fce_pkg::ST_OK)
        note_head(32'(got.cluster));
    end
  endtask

  // Response checker: every accepted response item against the oldest prediction.
  always @(posedge clk) begin
    fat_result_t seen;
    fat_result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      seen = mk_result(fce_pkg::status_t'(rsp.status), 32'(rsp.cluster), rsp.appended,
                       rsp.freed);
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected response: status %0d cluster %0d appended %0b freed %0b",
                   seen.status, seen.cluster, seen.appended, seen.freed);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          if (mismatches < 10)
            $display("mismatch: expected status %0d cluster %0d appended %0b freed %0b, %s",
                     want.status, want.cluster, want.appended, want.freed,
                     $sformatf("got status %0d cluster %0d appended %0b freed %0b",
                               seen.status, seen.cluster, seen.appended, seen.freed));
          mismatches++;
        end
      end
    end
  end

  // Response back pressure: a ready pattern that is picked anew at random.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 128);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       rsp.ready <= 1'b1;
      1:       rsp.ready <= 1'($urandom_range(0, 1));
      2:       rsp.ready <= (stall_tick % 4 == 0);
      default: rsp.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Run limit.
  initial begin
    #LIMIT_NS;
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence: reset, directed rows, then random phases under several marker settings.
  initial begin
    fat_result_t got;
    rst              = 1'b1;
    req.valid        = 1'b0;
    req.mode         = '0;
    req.head_cluster = '0;
    req.chain_index  = '0;
    req.entry_value  = '0;
    rsp.ready        = 1'b0;
    cfg.valid        = 1'b0;
    cfg.index        = fce_pkg::REG_FREE_MARKER;
    cfg.data         = '0;
    free_mk = fce_pkg::FREE_RESET;
    end_mk  = fce_pkg::END_RESET;
    foreach (link_mem[i]) link_mem[i] = fce_pkg::FREE_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed rows on the freshly cleared table with the reset markers.
    add_row(fce_pkg::MODE_LOAD,  4095, 0, 16'hFFFF, 1, fce_pkg::ST_OK, 4095, 0, 0);
    add_row(fce_pkg::MODE_ALLOC,    0, 0, 0,        1, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_MAP,      0, 0, 0,        1, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_MAP,      0, 1, 0,        1, fce_pkg::ST_OK,    1, 1, 0);
    add_row(fce_pkg::MODE_MAP,      0, 3, 0,        1, fce_pkg::ST_BEYOND, 0, 0, 0);
    add_row(fce_pkg::MODE_MAP,      0, 2, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_MAP,      0, 1, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_TRUNC,    0, 0, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_TRUNC,    0, 0, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    // Only one cluster left: nothing is released.
    add_row(fce_pkg::MODE_TRUNC,    0, 0, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_TRUNC, 4095, 0, 0,        1, fce_pkg::ST_OK, 4095, 0, 0);
    add_row(fce_pkg::MODE_MAP,   4095, 1, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    // A link that points past the table.
    add_row(fce_pkg::MODE_LOAD,     4, 0, 5,        1, fce_pkg::ST_OK,    4, 0, 0);
    add_row(fce_pkg::MODE_LOAD,     5, 0, 16'h1000, 1, fce_pkg::ST_OK,    5, 0, 0);
    add_row(fce_pkg::MODE_MAP,      4, 1, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_MAP,      4, 2, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_TRUNC,    4, 0, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    // A two-cluster loop with no end marker.
    add_row(fce_pkg::MODE_LOAD,     6, 0, 7,        1, fce_pkg::ST_OK,    6, 0, 0);
    add_row(fce_pkg::MODE_LOAD,     7, 0, 6,        1, fce_pkg::ST_OK,    7, 0, 0);
    add_row(fce_pkg::MODE_TRUNC,    6, 0, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_MAP,      6, 4096, 0,     0, fce_pkg::ST_OK,    0, 0, 0);
    // Walk through a free entry, then free the first chain head by hand.
    add_row(fce_pkg::MODE_MAP,      3, 1, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_LOAD,     0, 0, 16'h0000, 1, fce_pkg::ST_OK,    0, 0, 0);
    add_row(fce_pkg::MODE_ALLOC,    0, 0, 0,        0, fce_pkg::ST_OK,    0, 0, 0);
    foreach (dir_rows[i]) issue(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].res, got);
    note_head(0);
    note_head(4095);

    run_random(300);
    // Old end markers turn into links past the table.
    retune_markers(16'h0000, 16'h0FFF);
    run_random(150);
    // A free marker that hardly any entry holds: mostly no free cluster.
    retune_markers(16'h5A5A, 16'hFFFF);
    run_random(40);
    retune_markers(16'hFFFF, 16'h0000);
    run_random(80);
    // Equal markers: the end test comes first on a walk.
    retune_markers(16'h0000, 16'h0000);
    run_random(60);
    retune_markers(16'h0000, 16'hFFFF);
    run_random(170);

    drain(16);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
